### design/assert_macros.svh
// Assertion macros used by the checker file rbsi_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is ignored while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Concurrent assertion that is checked in every cycle, reset included.
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

### design/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg: types and constants for the ray/unit box slab intersect pipeline
// Holds the stage records, the box bounds and the one-bit divider step.
// ----------------------------------------------------------------------------
package rbsi_pkg;

   localparam int QuotW = 49;           // (|num| << 16) is 49 bits wide
   localparam int NumDivSteps = QuotW;  // one quotient bit per stage

   localparam logic signed [32:0] BoxHalf    = 33'sd32768;
   localparam logic signed [49:0] TUnbounded = 50'sh1_0000_0000_0000;
   localparam logic [31:0]        Sat32      = 32'hFFFF_FFFF;

   // Partial remainder and the shift word that turns dividend bits into quotient bits.
   typedef struct packed {
      logic [31:0]      rem;
      logic [QuotW-1:0] dq;
   } div_type;

   // Divider stage record: [axis][0 = lower box edge, 1 = upper box edge].
   typedef struct packed {
      div_type [1:0][1:0] dv;
      logic [1:0][31:0]   den;
      logic [1:0][1:0]    neg;
      logic [1:0]         moving;
      logic               miss;
   } pipe_type;

   // Signed, ordered slab parameters per axis.
   typedef struct packed {
      logic [1:0][49:0] ent;
      logic [1:0][49:0] ext;
      logic [1:0]       moving;
      logic             miss;
   } ord_type;

   // Running interval plus the axis that still has to be merged.
   typedef struct packed {
      logic [49:0] lo;
      logic [49:0] hi;
      logic [49:0] ent;
      logic [49:0] ext;
      logic        moving;
      logic        miss;
   } merge_type;

   // One restoring division step.
   function automatic div_type div_step(div_type s, logic [31:0] d);
      logic [32:0] t;
      logic [32:0] diff;
      div_type     r;
      t    = {s.rem, s.dq[QuotW-1]};
      diff = t - {1'b0, d};
      if (t >= {1'b0, d}) begin
         r.rem = diff[31:0];
         r.dq  = {s.dq[QuotW-2:0], 1'b1};
      end else begin
         r.rem = t[31:0];
         r.dq  = {s.dq[QuotW-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

### design/ray_unit_box_slab_intersect.sv
// ----------------------------------------------------------------------------
// ray_unit_box_slab_intersect: 2D ray against unit box, slab test
// Computes entry and exit parameters of a Q16.16 ray against the box
// [-0.5, 0.5] x [-0.5, 0.5] with a fully pipelined bit-per-stage divider.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                                   | Direction
//   --------+-----------------------------------------+----------
//   req     | req_valid/ready, origin_x/y, dir_x/y    | in
//   rsp     | rsp_valid/ready, hit, t_in, t_out       | out
//   csr     | csr_valid/ready, csr_dir_threshold      | in
//
// One request enters per cycle while req_ready is high; its response passes
// through one input stage, 49 divider stages, three merge stages and the output
// register. The depth is set by the 49-bit restoring divider, one quotient
// bit per stage. Reset is synchronous and clears every valid bit and the
// threshold. Each stage holds while its successor is full and stalled, so a
// stalled response never blocks empty stages upstream from filling.
module ray_unit_box_slab_intersect (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_dir_threshold,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_origin_x,
   input  logic [31:0] req_origin_y,
   input  logic [31:0] req_dir_x,
   input  logic [31:0] req_dir_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_hit,
   output logic [31:0] rsp_t_in,
   output logic [31:0] rsp_t_out
);

   localparam int N = rbsi_pkg::NumDivSteps;

   // The threshold register is always writable.
   logic [15:0] thr_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_valid) begin
         thr_ff <= csr_dir_threshold;
      end
   end

   // Stage 0 loads the request; stages 1..N each add one quotient bit.
   rbsi_pkg::pipe_type d_ff [0:N];
   logic [N:0]         dv_ff;
   logic [N+1:0]       d_rdy;
   rbsi_pkg::pipe_type s0_in;

   rbsi_pkg::ord_type   p1_ff, p1_in;
   rbsi_pkg::merge_type p2_ff, p2_in, p3_ff, p3_in;
   logic                p1v_ff, p2v_ff, p3v_ff;
   logic                p1_rdy, p2_rdy, p3_rdy, out_rdy;

   // A stage may load when it is empty or its contents move on.
   assign out_rdy = !rsp_valid || rsp_ready;
   assign p3_rdy  = !p3v_ff || out_rdy;
   assign p2_rdy  = !p2v_ff || p3_rdy;
   assign p1_rdy  = !p1v_ff || p2_rdy;
   assign d_rdy[N+1] = p1_rdy;

   for (genvar k = 0; k <= N; k++) begin : g_rdy
      assign d_rdy[k] = !dv_ff[k] || d_rdy[k+1];
   end

   assign req_ready = d_rdy[0];

   // Input stage: slab numerators, magnitudes, signs, the moving test and the still-axis miss test.
   always_comb begin
      logic [1:0][31:0]   org;
      logic [1:0][31:0]   dir;
      logic signed [32:0] o33;
      logic signed [32:0] num [2];
      logic [32:0]        mag;
      s0_in = '0;
      org = {req_origin_y, req_origin_x};
      dir = {req_dir_y, req_dir_x};
      for (int a = 0; a < 2; a++) begin
         o33    = $signed({org[a][31], org[a]});
         num[0] = -rbsi_pkg::BoxHalf - o33;
         num[1] = rbsi_pkg::BoxHalf - o33;
         s0_in.den[a] = dir[a][31] ? (32'd0 - dir[a]) : dir[a];
         s0_in.moving[a] = s0_in.den[a] > {16'd0, thr_ff};
         for (int b = 0; b < 2; b++) begin
            mag = num[b][32] ? (33'd0 - num[b]) : num[b];
            s0_in.dv[a][b].rem = '0;
            s0_in.dv[a][b].dq  = {mag, 16'd0};
            s0_in.neg[a][b]    = num[b][32] ^ dir[a][31];
         end
         if (!s0_in.moving[a] && (o33 < -rbsi_pkg::BoxHalf || o33 > rbsi_pkg::BoxHalf)) begin
            s0_in.miss = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (d_rdy[0]) begin
         dv_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (d_rdy[0]) begin
         d_ff[0] <= s0_in;
      end
   end

   // Divider stages: both bounds of both axes advance one bit per stage.
   for (genvar k = 1; k <= N; k++) begin : g_div
      rbsi_pkg::pipe_type d_in;

      always_comb begin
         d_in = d_ff[k-1];
         for (int a = 0; a < 2; a++) begin
            for (int b = 0; b < 2; b++) begin
               d_in.dv[a][b] = rbsi_pkg::div_step(d_ff[k-1].dv[a][b], d_ff[k-1].den[a]);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k] <= 1'b0;
         end else if (d_rdy[k]) begin
            dv_ff[k] <= dv_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (d_rdy[k]) begin
            d_ff[k] <= d_in;
         end
      end
   end

   // Merge stage 1: apply signs and put each axis's pair in order.
   always_comb begin
      logic [49:0] qa;
      logic [49:0] qb;
      p1_in        = '0;
      p1_in.moving = d_ff[N].moving;
      p1_in.miss   = d_ff[N].miss;
      for (int a = 0; a < 2; a++) begin
         qa = {1'b0, d_ff[N].dv[a][0].dq};
         qb = {1'b0, d_ff[N].dv[a][1].dq};
         if (d_ff[N].neg[a][0]) begin
            qa = 50'd0 - qa;
         end
         if (d_ff[N].neg[a][1]) begin
            qb = 50'd0 - qb;
         end
         if ($signed(qa) > $signed(qb)) begin
            p1_in.ent[a] = qb;
            p1_in.ext[a] = qa;
         end else begin
            p1_in.ent[a] = qa;
            p1_in.ext[a] = qb;
         end
      end
   end

   // Merge stage 2: narrow [0, unbounded] by the x axis.
   always_comb begin
      p2_in        = '0;
      p2_in.lo     = '0;
      p2_in.hi     = rbsi_pkg::TUnbounded;
      p2_in.ent    = p1_ff.ent[1];
      p2_in.ext    = p1_ff.ext[1];
      p2_in.moving = p1_ff.moving[1];
      p2_in.miss   = p1_ff.miss;
      if (p1_ff.moving[0]) begin
         if ($signed(p1_ff.ent[0]) > 50'sd0) begin
            p2_in.lo = p1_ff.ent[0];
         end
         if ($signed(p1_ff.ext[0]) < rbsi_pkg::TUnbounded) begin
            p2_in.hi = p1_ff.ext[0];
         end
      end
   end

   // Merge stage 3: narrow by the y axis.
   always_comb begin
      p3_in = p2_ff;
      if (p2_ff.moving) begin
         if ($signed(p2_ff.ent) > $signed(p2_ff.lo)) begin
            p3_in.lo = p2_ff.ent;
         end
         if ($signed(p2_ff.ext) < $signed(p2_ff.hi)) begin
            p3_in.hi = p2_ff.ext;
         end
      end
   end

   // Output stage: final miss test and saturation to 32 bits.
   logic        hit_in;
   logic [31:0] t_in_in, t_out_in;
   logic        hit_ff;
   logic [31:0] t_in_ff, t_out_ff;
   logic        rv_ff;

   always_comb begin
      hit_in   = !(p3_ff.miss || $signed(p3_ff.hi) < 50'sd0
                   || $signed(p3_ff.lo) > $signed(p3_ff.hi));
      t_in_in  = '0;
      t_out_in = '0;
      if (hit_in) begin
         // The lower end is never negative here, so only the upper limit matters.
         if (p3_ff.lo[49:32] != '0) begin
            t_in_in = rbsi_pkg::Sat32;
         end else begin
            t_in_in = p3_ff.lo[31:0];
         end
         if (p3_ff.hi[49:32] != '0) begin
            t_out_in = rbsi_pkg::Sat32;
         end else begin
            t_out_in = p3_ff.hi[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1v_ff <= 1'b0;
         p2v_ff <= 1'b0;
         p3v_ff <= 1'b0;
         rv_ff  <= 1'b0;
      end else begin
         if (p1_rdy) begin
            p1v_ff <= dv_ff[N];
         end
         if (p2_rdy) begin
            p2v_ff <= p1v_ff;
         end
         if (p3_rdy) begin
            p3v_ff <= p2v_ff;
         end
         if (out_rdy) begin
            rv_ff <= p3v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p1_rdy) begin
         p1_ff <= p1_in;
      end
      if (p2_rdy) begin
         p2_ff <= p2_in;
      end
      if (p3_rdy) begin
         p3_ff <= p3_in;
      end
      if (out_rdy) begin
         hit_ff   <= hit_in;
         t_in_ff  <= t_in_in;
         t_out_ff <= t_out_in;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_hit   = hit_ff;
   assign rsp_t_in  = t_in_ff;
   assign rsp_t_out = t_out_ff;

endmodule

### design/rbsi_checker.sv
// ----------------------------------------------------------------------------
// rbsi_checker: port-level checks for the slab intersect block
// Watches the response channel and the reset behavior.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbsi_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_hit,
   input logic [31:0] rsp_t_in,
   input logic [31:0] rsp_t_out
);

   // A stalled response keeps its valid and payload.
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_t_in) && $stable(rsp_t_out))

   // A miss reports both parameters as zero.
   `ASSERT_CLK_RST(a_miss_zero, clock, reset, rsp_valid && !rsp_hit |-> rsp_t_in == 32'd0 && rsp_t_out == 32'd0)

   // On a hit the entry never lies beyond the exit.
   `ASSERT_CLK_RST(a_hit_order, clock, reset, rsp_valid && rsp_hit |-> rsp_t_in <= rsp_t_out)

   // Reset empties the pipeline.
   `ASSERT_CLK(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind ray_unit_box_slab_intersect rbsi_checker u_rbsi_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_hit   (rsp_hit),
   .rsp_t_in  (rsp_t_in),
   .rsp_t_out (rsp_t_out)
);
